/* src/dtw_pkg.sv */
package dtw_pkg;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StIllegal = 3'd1;
  localparam logic [2:0] StDigits  = 3'd2;
  localparam logic [2:0] StYear    = 3'd3;
  localparam logic [2:0] StMonth   = 3'd4;
  localparam logic [2:0] StDay     = 3'd5;

  localparam logic [1:0] FieldYear  = 2'd0;
  localparam logic [1:0] FieldMonth = 2'd1;
  localparam logic [1:0] FieldDay   = 2'd2;

  localparam logic [13:0] YearMax = 14'd9999;

  // One finished line, handed from the parser to the checker.
  typedef struct packed {
    logic        illegal;
    logic        too_many;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
  } line_rec_t;

  typedef struct packed {
    logic [2:0] offset;
    logic [4:0] length;
  } month_info_t;

  function automatic month_info_t month_info(input logic [6:0] month);
    month_info_t mi;
    case (month)
      7'd1:    mi = '{offset: 3'd0, length: 5'd31};
      7'd2:    mi = '{offset: 3'd3, length: 5'd28};
      7'd3:    mi = '{offset: 3'd2, length: 5'd31};
      7'd4:    mi = '{offset: 3'd5, length: 5'd30};
      7'd5:    mi = '{offset: 3'd0, length: 5'd31};
      7'd6:    mi = '{offset: 3'd3, length: 5'd30};
      7'd7:    mi = '{offset: 3'd5, length: 5'd31};
      7'd8:    mi = '{offset: 3'd1, length: 5'd31};
      7'd9:    mi = '{offset: 3'd4, length: 5'd30};
      7'd10:   mi = '{offset: 3'd6, length: 5'd31};
      7'd11:   mi = '{offset: 3'd2, length: 5'd30};
      7'd12:   mi = '{offset: 3'd4, length: 5'd31};
      default: mi = '{offset: 3'd0, length: 5'd0};
    endcase
    return mi;
  endfunction

endpackage

/* src/dtw_front.sv */
module dtw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_input,
  input  logic               fifo_full,
  output logic               push,
  output dtw_pkg::line_rec_t push_data
);

  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [1:0]  field_r, field_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        too_many_r, too_many_nxt;
  logic        illegal_r, illegal_nxt;
  logic        nonempty_r, nonempty_nxt;

  logic [13:0] t_year;
  logic [6:0]  t_month, t_day;
  logic [1:0]  t_field;
  logic [2:0]  t_count, limit;
  logic        t_too_many, t_illegal;
  logic        accept, is_term, is_digit, close_now;
  logic [3:0]  digit;
  dtw_pkg::line_rec_t rec;
  logic        rec_nonempty;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign is_term  = (in_char_code == dtw_pkg::CharLf) || (in_char_code == dtw_pkg::CharCr);
  assign is_digit = (in_char_code >= dtw_pkg::CharZero) && (in_char_code <= dtw_pkg::CharNine);
  assign digit    = in_char_code[3:0];
  assign limit    = (field_r == dtw_pkg::FieldYear) ? 3'd4 : 3'd2;

  // State after taking the byte as a line character.
  always_comb begin
    t_year     = year_r;
    t_month    = month_r;
    t_day      = day_r;
    t_field    = field_r;
    t_count    = count_r;
    t_too_many = too_many_r;
    t_illegal  = illegal_r;
    if (is_digit) begin
      if (field_r <= dtw_pkg::FieldDay) begin
        if (count_r >= limit) begin
          t_too_many = 1'b1;
        end else begin
          t_count = count_r + 3'd1;
          case (field_r)
            dtw_pkg::FieldYear:  t_year  = {year_r[10:0], 3'b000} + {year_r[12:0], 1'b0}
                                           + {10'd0, digit};
            dtw_pkg::FieldMonth: t_month = {month_r[3:0], 3'b000} + {month_r[5:0], 1'b0}
                                           + {3'd0, digit};
            default:             t_day   = {day_r[3:0], 3'b000} + {day_r[5:0], 1'b0}
                                           + {3'd0, digit};
          endcase
        end
      end
    end else if (in_char_code == dtw_pkg::CharSlash) begin
      if (field_r >= dtw_pkg::FieldDay) begin
        t_illegal = 1'b1;
      end else begin
        t_field = field_r + 2'd1;
        t_count = 3'd0;
      end
    end else begin
      t_illegal = 1'b1;
    end
  end

  // A terminator closes the line as it stands; end of input closes it after the byte.
  assign close_now    = is_term || in_end_of_input;
  assign rec_nonempty = is_term ? nonempty_r : 1'b1;

  always_comb begin
    if (is_term) begin
      rec = '{illegal: illegal_r, too_many: too_many_r, year: year_r,
              month: month_r, day: day_r};
    end else begin
      rec = '{illegal: t_illegal, too_many: t_too_many, year: t_year,
              month: t_month, day: t_day};
    end
  end

  assign push      = accept && close_now && rec_nonempty;
  assign push_data = rec;

  always_comb begin
    year_nxt     = year_r;
    month_nxt    = month_r;
    day_nxt      = day_r;
    field_nxt    = field_r;
    count_nxt    = count_r;
    too_many_nxt = too_many_r;
    illegal_nxt  = illegal_r;
    nonempty_nxt = nonempty_r;
    if (accept) begin
      if (close_now) begin
        year_nxt     = '0;
        month_nxt    = '0;
        day_nxt      = '0;
        field_nxt    = dtw_pkg::FieldYear;
        count_nxt    = '0;
        too_many_nxt = 1'b0;
        illegal_nxt  = 1'b0;
        nonempty_nxt = 1'b0;
      end else begin
        year_nxt     = t_year;
        month_nxt    = t_month;
        day_nxt      = t_day;
        field_nxt    = t_field;
        count_nxt    = t_count;
        too_many_nxt = t_too_many;
        illegal_nxt  = t_illegal;
        nonempty_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r     <= '0;
      month_r    <= '0;
      day_r      <= '0;
      field_r    <= dtw_pkg::FieldYear;
      count_r    <= '0;
      too_many_r <= 1'b0;
      illegal_r  <= 1'b0;
      nonempty_r <= 1'b0;
    end else begin
      year_r     <= year_nxt;
      month_r    <= month_nxt;
      day_r      <= day_nxt;
      field_r    <= field_nxt;
      count_r    <= count_nxt;
      too_many_r <= too_many_nxt;
      illegal_r  <= illegal_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

endmodule

/* src/dtw_fifo.sv */
module dtw_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dtw_pkg::line_rec_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output dtw_pkg::line_rec_t pop_data
);

  dtw_pkg::line_rec_t mem [dtw_pkg::FifoDepth];

  logic [dtw_pkg::FifoPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dtw_pkg::FifoPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dtw_pkg::FifoPtrW:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign full      = (count_r == (dtw_pkg::FifoPtrW+1)'(dtw_pkg::FifoDepth));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (dtw_pkg::FifoPtrW+1)'(dtw_pkg::FifoDepth))
    else $error("line queue count over depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[dtw_pkg::FifoPtrW-1:0])
    else $error("line queue pointers disagree with count");
`endif

endmodule

/* src/dtw_back.sv */
module dtw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_valid,
  input  dtw_pkg::line_rec_t rec,
  output logic               rec_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [2:0]         out_weekday
);

  logic advance;

  // Stage A: divide by 100 and table lookup
  logic               a_valid_r;
  dtw_pkg::line_rec_t a_rec_r;
  logic [13:0]        a_yadj_r;
  logic [7:0]         a_qy_r, a_qa_r;
  logic [2:0]         a_off_r;
  logic [4:0]         a_len_r;

  // Stage B: status and day sum
  logic               b_valid_r;
  logic [2:0]         b_status_r;
  logic [14:0]        b_sum_r;

  // Output register
  logic               out_valid_r;
  logic [2:0]         out_status_r, out_weekday_r;

  logic [13:0]        yadj;
  logic [26:0]        prod_y, prod_a;
  dtw_pkg::month_info_t mi;

  logic               leap, cent;
  logic [15:0]        qy_x100;
  logic [4:0]         lim;
  logic [2:0]         status;
  logic [14:0]        sum;
  logic [5:0]         fold1;
  logic [3:0]         fold2;
  logic [2:0]         wd;

  assign advance = !out_valid_r || !out_stall;
  assign rec_pop = advance && rec_valid;

  // Floor division by 100 through the reciprocal 5243 / 2^19, exact below 43699.
  assign yadj   = rec.year - {13'd0, (rec.month < 7'd3)};
  assign prod_y = 27'(rec.year) * 27'd5243;
  assign prod_a = 27'(yadj) * 27'd5243;
  assign mi     = dtw_pkg::month_info(rec.month);

  always_ff @(posedge clk) begin
    if (advance) begin
      a_rec_r  <= rec;
      a_yadj_r <= yadj;
      a_qy_r   <= prod_y[26:19];
      a_qa_r   <= prod_a[26:19];
      a_off_r  <= mi.offset;
      a_len_r  <= mi.length;
    end
  end

  assign qy_x100 = 16'(a_qy_r) * 16'd100;
  assign cent    = (qy_x100 == {2'b00, a_rec_r.year});
  assign leap    = (a_rec_r.year[1:0] == 2'b00) && (!cent || (a_qy_r[1:0] == 2'b00));
  assign lim     = ((a_rec_r.month == 7'd2) && leap) ? 5'd29 : a_len_r;

  always_comb begin
    if (a_rec_r.illegal) begin
      status = dtw_pkg::StIllegal;
    end else if (a_rec_r.too_many) begin
      status = dtw_pkg::StDigits;
    end else if ((a_rec_r.year == 14'd0) || (a_rec_r.year > dtw_pkg::YearMax)) begin
      status = dtw_pkg::StYear;
    end else if ((a_rec_r.month == 7'd0) || (a_rec_r.month > 7'd12)) begin
      status = dtw_pkg::StMonth;
    end else if ((a_rec_r.day == 7'd0) || (a_rec_r.day > {2'b00, lim})) begin
      status = dtw_pkg::StDay;
    end else begin
      status = dtw_pkg::StOk;
    end
  end

  assign sum = {1'b0, a_yadj_r} + {3'd0, a_yadj_r[13:2]} - {7'd0, a_qa_r}
             + {9'd0, a_qa_r[7:2]} + {12'd0, a_off_r} + {8'd0, a_rec_r.day};

  always_ff @(posedge clk) begin
    if (advance) begin
      b_status_r <= status;
      b_sum_r    <= sum;
    end
  end

  // Mod 7 by summing octal digits, since 8 is 1 mod 7.
  assign fold1 = {3'd0, b_sum_r[2:0]} + {3'd0, b_sum_r[5:3]} + {3'd0, b_sum_r[8:6]}
               + {3'd0, b_sum_r[11:9]} + {3'd0, b_sum_r[14:12]};
  assign fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
  assign wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r  <= b_status_r;
      out_weekday_r <= (b_status_r == dtw_pkg::StOk) ? wd : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r   <= rec_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_weekday = out_weekday_r;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= dtw_pkg::StDay))
    else $error("result status out of range");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_weekday_r <= 3'd6))
    else $error("weekday out of range");

  a_weekday_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != dtw_pkg::StOk)) |-> (out_weekday_r == 3'd0))
    else $error("weekday set on failed date");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    rec_pop |=> a_valid_r)
    else $error("popped line lost before stage A");
`endif

endmodule

/* src/date_text_weekday_parser.sv */
// Date text to weekday parser.
// Input channel (in_valid / in_stall): one text byte per beat in in_char_code,
// with in_end_of_input marking the last byte of the text. Lines hold
// year/month/day in decimal and end at CR, LF or after the end-of-input byte.
// Output channel (out_valid / out_stall): one beat per non-empty line, with
// out_status (0 ok, 1 illegal char, 2 digit count, 3 year, 4 month, 5 day)
// and out_weekday (0 Sunday .. 6 Saturday, 0 when status is not ok).
// Throughput: one byte per cycle and one result per cycle while neither channel stalls.
// Path: a result goes from the beat that closes its line through the queue,
// the divide stage, the check stage and the output register.
// The parser takes bytes while its 4-entry line queue has room; in_stall
// rises only when that queue is full. A stall on the output holds the
// check pipeline, the queue then fills, and the input stalls after it.
// Reset (rst_n low, synchronous) clears the partial line, the queue and all
// pipeline valid bits; no result is pending afterward.
module date_text_weekday_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [2:0] out_weekday
);

  logic               fifo_full, push, pop, pop_valid;
  dtw_pkg::line_rec_t push_data, pop_data;

  dtw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_end_of_input (in_end_of_input),
    .fifo_full       (fifo_full),
    .push            (push),
    .push_data       (push_data)
  );

  dtw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  dtw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_valid   (pop_valid),
    .rec         (pop_data),
    .rec_pop     (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_weekday (out_weekday)
  );

endmodule

/* test/date_text_weekday_parser_test.sv */
`timescale 1ns / 1ps

module date_text_weekday_parser_test;

  localparam int QuietLimit   = 4000;
  localparam int OutHoldCycles = 400;

  typedef enum int {EndLf, EndCr, EndCrLf, EndMark, EndLfMark} line_end_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] weekday;
  } date_verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;
  logic [2:0] out_weekday;

  date_text_weekday_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_weekday(out_weekday)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Line parser shadow state
  logic [13:0] yr_val;
  logic [6:0]  mo_val;
  logic [6:0]  dy_val;
  logic [1:0]  field_pos;
  logic [2:0]  field_digits;
  logic        digit_overflow;
  logic        bad_char;
  logic        line_open;

  int month_days  [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int month_shift [1:12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  date_verdict_t expected_verdicts[$];
  logic [7:0]    text_buf[$];

  int  fail_count = 0;
  int  bytes_sent = 0;
  int  quiet_cycles = 0;
  bit  idling_on = 1'b1;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;

  task automatic clear_date_line();
    yr_val = '0;
    mo_val = '0;
    dy_val = '0;
    field_pos = dtw_pkg::FieldYear;
    field_digits = '0;
    digit_overflow = 1'b0;
    bad_char = 1'b0;
    line_open = 1'b0;
  endtask

  task automatic close_date_line();
    date_verdict_t v;
    int            lim;
    int            y;
    if (line_open) begin
      v.status = dtw_pkg::StOk;
      v.weekday = 3'd0;
      if (bad_char) begin
        v.status = dtw_pkg::StIllegal;
      end else if (digit_overflow) begin
        v.status = dtw_pkg::StDigits;
      end else if (yr_val < 1 || yr_val > dtw_pkg::YearMax) begin
        v.status = dtw_pkg::StYear;
      end else if (mo_val < 1 || mo_val > 12) begin
        v.status = dtw_pkg::StMonth;
      end else begin
        lim = month_days[mo_val];
        if (mo_val == 2 && ((yr_val % 4 == 0 && yr_val % 100 != 0) || yr_val % 400 == 0))
          lim = 29;
        if (dy_val < 1 || dy_val > lim)
          v.status = dtw_pkg::StDay;
      end
      if (v.status == dtw_pkg::StOk) begin
        y = int'(yr_val);
        if (mo_val < 3)
          y = y - 1;
        v.weekday = 3'((y + y / 4 - y / 100 + y / 400 + month_shift[mo_val]
                        + int'(dy_val)) % 7);
      end
      expected_verdicts.push_back(v);
    end
    clear_date_line();
  endtask

  task automatic predict_char(input logic [7:0] c, input logic eoi);
    int lim;
    if (c == dtw_pkg::CharLf || c == dtw_pkg::CharCr) begin
      close_date_line();
    end else begin
      line_open = 1'b1;
      if (c >= dtw_pkg::CharZero && c <= dtw_pkg::CharNine) begin
        lim = (field_pos == dtw_pkg::FieldYear) ? 4 : 2;
        if (field_digits >= lim) begin
          digit_overflow = 1'b1;
        end else begin
          field_digits = field_digits + 3'd1;
          case (field_pos)
            dtw_pkg::FieldYear:  yr_val = 14'(yr_val * 10 + (c - dtw_pkg::CharZero));
            dtw_pkg::FieldMonth: mo_val = 7'(mo_val * 10 + (c - dtw_pkg::CharZero));
            default:             dy_val = 7'(dy_val * 10 + (c - dtw_pkg::CharZero));
          endcase
        end
      end else if (c == dtw_pkg::CharSlash) begin
        if (field_pos == dtw_pkg::FieldDay) begin
          bad_char = 1'b1;
        end else begin
          field_pos = field_pos + 2'd1;
          field_digits = '0;
        end
      end else begin
        bad_char = 1'b1;
      end
      if (eoi)
        close_date_line();
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_char(c, eoi);
    bytes_sent++;
  endtask

  task automatic send_buf(input line_end_t ending);
    int last;
    if (idling_on) begin
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 5;
        default: send_idle_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 5;
        default: recv_idle_pct = 25;
      endcase
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    last = text_buf.size() - 1;
    foreach (text_buf[i])
      send_byte(text_buf[i], ending == EndMark && i == last);
    case (ending)
      EndLf:     send_byte(dtw_pkg::CharLf, 1'b0);
      EndCr:     send_byte(dtw_pkg::CharCr, 1'b0);
      EndCrLf: begin
        send_byte(dtw_pkg::CharCr, 1'b0);
        send_byte(dtw_pkg::CharLf, 1'b0);
      end
      EndLfMark: send_byte(dtw_pkg::CharLf, 1'b1);
      default: ;
    endcase
    text_buf.delete();
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) text_buf.push_back(s[i]);
  endtask

  task automatic add_number(input int unsigned value, input int width);
    string s;
    s = $sformatf("%0d", value);
    while (s.len() < width) s = {"0", s};
    add_text(s);
  endtask

  task automatic send_text(input string s, input line_end_t ending);
    add_text(s);
    send_buf(ending);
  endtask

  function automatic int pad_width(input int unsigned value);
    string s;
    int    w;
    s = $sformatf("%0d", value);
    w = s.len();
    if ($urandom_range(0, 7) == 0)
      w = w + 1;
    return w;
  endfunction

  // Well-formed date text with random content, plus broken lines and noise.
  task automatic send_random_line();
    int unsigned yr, mo, dy;
    int          kind, pos, pick;
    line_end_t   ending;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      case ($urandom_range(0, 4))
        0: yr = $urandom_range(1, 30);
        1: yr = 100 * $urandom_range(1, 99);
        2: yr = $urandom_range(9990, 9999);
        3: yr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9999);
        default: yr = $urandom_range(1, 9999);
      endcase
      mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1:    dy = $urandom_range(0, 99);
        2, 3, 4: dy = $urandom_range(28, 31);
        default: dy = $urandom_range(1, 28);
      endcase
      add_number(yr, pad_width(yr));
      add_text("/");
      add_number(mo, pad_width(mo));
      add_text("/");
      add_number(dy, pad_width(dy));
      if (kind >= 76) begin
        // break the line: overwrite, drop or insert one byte
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: text_buf[pos] = 8'($urandom_range(0, 255));
          1: text_buf.delete(pos);
          2: text_buf.insert(pos, dtw_pkg::CharSlash);
          default: text_buf.insert(pos, 8'(dtw_pkg::CharZero + $urandom_range(0, 9)));
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1) == 0) begin
          pick = $urandom_range(0, 10);
          b = (pick == 10) ? dtw_pkg::CharSlash : 8'(dtw_pkg::CharZero + pick);
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        text_buf.push_back(b);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 35)      ending = EndLf;
    else if (pick < 55) ending = EndCr;
    else if (pick < 75) ending = EndCrLf;
    else if (pick < 90) ending = EndMark;
    else                ending = EndLfMark;
    send_buf(ending);
    if ($urandom_range(0, 19) == 0)
      send_byte(($urandom_range(0, 1) == 0) ? dtw_pkg::CharLf : dtw_pkg::CharCr,
                1'($urandom_range(0, 1)));
  endtask

  task automatic test_valid_dates();
    send_text("1/1/1", EndLf);
    send_text("9999/12/31", EndCr);
    send_text("2000/2/29", EndLf);
    send_text("2024/02/29", EndMark);
  endtask

  task automatic test_range_errors();
    send_text("1900/2/29", EndLf);
    send_text("0/1/1", EndLf);
    send_text("1/13/1", EndLf);
    send_text("1/0/1", EndCr);
    send_text("1/4/31", EndLf);
    send_text("1/1/0", EndLf);
    send_text("2023", EndLf);
    send_text("/", EndLf);
  endtask

  task automatic test_format_errors();
    send_text("1/2/3/4", EndLf);
    send_text("12a/1/1", EndLf);
    send_text("12345x/1/1", EndLf);
    send_text("12345/1/1", EndLf);
    send_text("1/123/1", EndCr);
    send_text("1/1/123", EndLf);
    send_byte(8'h00, 1'b0);
    send_byte(dtw_pkg::CharLf, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_line_endings();
    send_text("2023/1/1", EndCrLf);
    send_byte(dtw_pkg::CharLf, 1'b0);
    send_text("5/5/5", EndLfMark);
    send_byte(dtw_pkg::CharCr, 1'b1);
    send_text("x", EndMark);
  endtask

  task automatic test_random_lines(input int byte_goal);
    idling_on = 1'b1;
    while (bytes_sent < byte_goal) send_random_line();
  endtask

  // Hold the output long enough for the line queue to fill and stall the input.
  task automatic test_output_hold();
    idling_on = 1'b0;
    hold_request = 1'b1;
    repeat (30) send_text("7/7/7", EndLf);
  endtask

  task automatic test_unbroken_stream(input int byte_goal);
    idling_on = 1'b0;
    while (bytes_sent < byte_goal) send_random_line();
  endtask

  // Result checker and receiver-side stall
  always @(posedge clk) begin
    date_verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: status %0d weekday %0d", out_status, out_weekday);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_weekday !== want.weekday) begin
          $error("weekday: expected %0d, actual %0d", want.weekday, out_weekday);
          fail_count++;
        end
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = OutHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    clear_date_line();
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_valid_dates();
    test_range_errors();
    test_format_errors();
    test_line_endings();
    test_random_lines(900);
    test_output_hold();
    test_unbroken_stream(1350);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
